// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define BNF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bnf assertion failed");

// next-cycle implication, disabled while reset is active
`define BNF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bnf assertion failed");

`endif

// ----- hdl/bnf_pkg.sv -----
// ---------------------------------------------------------------------------
// bnf_pkg
// shared constants, codes and command types of the biquad notch filter
// ---------------------------------------------------------------------------
package bnf_pkg;

  // fixed-point format
  localparam int unsigned COEF_FRAC_BITS = 30;
  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned COEF_W         = 32;
  localparam int unsigned ACC_W          = 64;
  localparam int unsigned CFG_IDX_W      = 3;

  // coefficient register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

  // coefficient reset values (default notch)
  localparam logic signed [COEF_W-1:0] RST_B0 = 32'sd1068240085;
  localparam logic signed [COEF_W-1:0] RST_B1 = -32'sd2031913388;
  localparam logic signed [COEF_W-1:0] RST_B2 = 32'sd1068240085;
  localparam logic signed [COEF_W-1:0] RST_A1 = -32'sd2031913388;
  localparam logic signed [COEF_W-1:0] RST_A2 = 32'sd1062738346;

  // operand pairs of the shared multiplier
  typedef enum logic [2:0] {
    MUL_B0_IN,
    MUL_B1_X,
    MUL_A1_Y,
    MUL_B2_X,
    MUL_A2_Y
  } mul_sel_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MB1,
    ST_MA1,
    ST_MB2,
    ST_MA2,
    ST_UPD,
    ST_PUSH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     take;
    logic     ld_y;
    logic     ld_acc_d2;
    logic     ld_d1;
    logic     ld_acc_p;
    logic     ld_d2;
    logic     ld_out;
  } cmd_t;

endpackage

// ----- hdl/biquad_notch_filter_q30.sv -----
// ---------------------------------------------------------------------------
// biquad_notch_filter_q30
// second-order iir section, transposed direct form ii, q30 coefficients
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_       input      in_valid/in_ready    in_sample_in[31:0], in_restart
//  out_      output     out_valid/out_ready  out_sample_out[31:0]
//  cfg_      input      cfg_we               cfg_index[2:0], cfg_data[31:0]
//
//  one item at a time: five products share one registered 32x32
//  multiplier, the first taken in the cycle the item is accepted
//  the result sits in its own register; the next item is taken while it waits,
//  and the sequencer holds before its final step only if the previous result
//  has still not been taken
//  reset (rst_n low, synchronous) loads the default coefficients and clears
//  both delays
// ---------------------------------------------------------------------------
module biquad_notch_filter_q30 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bnf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bnf_pkg::COEF_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bnf_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bnf_pkg::SAMPLE_W-1:0] out_sample_out
);

  bnf_pkg::cmd_t cmd;

  // sequencer
  bnf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic
  bnf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample_in   (in_sample_in),
    .in_restart     (in_restart),
    .cmd            (cmd),
    .out_sample_out (out_sample_out)
  );

endmodule

// ----- hdl/bnf_ctrl.sv -----
// ---------------------------------------------------------------------------
// bnf_ctrl
// sequencer for one item: five products through the shared multiplier
// ---------------------------------------------------------------------------
module bnf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bnf_pkg::cmd_t cmd
);

  bnf_pkg::state_t state_r;
  bnf_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            accept;
  logic            slot_free;

  assign in_ready  = (state_r == bnf_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bnf_pkg::ST_IDLE: if (accept) state_nxt = bnf_pkg::ST_MB1;
      bnf_pkg::ST_MB1:  state_nxt = bnf_pkg::ST_MA1;
      bnf_pkg::ST_MA1:  state_nxt = bnf_pkg::ST_MB2;
      bnf_pkg::ST_MB2:  state_nxt = bnf_pkg::ST_MA2;
      bnf_pkg::ST_MA2:  state_nxt = bnf_pkg::ST_UPD;
      bnf_pkg::ST_UPD:  state_nxt = slot_free ? bnf_pkg::ST_IDLE : bnf_pkg::ST_PUSH;
      bnf_pkg::ST_PUSH: if (slot_free) state_nxt = bnf_pkg::ST_IDLE;
      default:          state_nxt = bnf_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = bnf_pkg::MUL_B0_IN;
    unique case (state_r)
      bnf_pkg::ST_IDLE: begin
        cmd.mul_en = accept;
        cmd.take   = accept;
      end
      bnf_pkg::ST_MB1: begin
        cmd.ld_y    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bnf_pkg::MUL_B1_X;
      end
      bnf_pkg::ST_MA1: begin
        cmd.ld_acc_d2 = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = bnf_pkg::MUL_A1_Y;
      end
      bnf_pkg::ST_MB2: begin
        cmd.ld_d1   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bnf_pkg::MUL_B2_X;
      end
      bnf_pkg::ST_MA2: begin
        cmd.ld_acc_p = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = bnf_pkg::MUL_A2_Y;
      end
      bnf_pkg::ST_UPD: begin
        cmd.ld_d2  = 1'b1;
        cmd.ld_out = slot_free;
      end
      bnf_pkg::ST_PUSH: begin
        cmd.ld_out = slot_free;
      end
      default: begin
        cmd.mul_en = 1'b0;
      end
    endcase
  end

  // result slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bnf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/bnf_dp.sv -----
// ---------------------------------------------------------------------------
// bnf_dp
// coefficient registers, shared 32x32 multiplier, accumulator and delays
// ---------------------------------------------------------------------------
module bnf_dp (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_we,
  input  logic [bnf_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [bnf_pkg::COEF_W-1:0]                 cfg_data,
  input  logic signed [bnf_pkg::SAMPLE_W-1:0]        in_sample_in,
  input  logic                                       in_restart,
  input  bnf_pkg::cmd_t                              cmd,
  output logic signed [bnf_pkg::SAMPLE_W-1:0]        out_sample_out
);

  logic signed [bnf_pkg::COEF_W-1:0]   b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [bnf_pkg::SAMPLE_W-1:0] x_r;
  logic signed [bnf_pkg::SAMPLE_W-1:0] y_r;
  logic signed [bnf_pkg::SAMPLE_W-1:0] out_r;
  logic signed [bnf_pkg::ACC_W-1:0]    prod_r;
  logic signed [bnf_pkg::ACC_W-1:0]    acc_r;
  logic signed [bnf_pkg::ACC_W-1:0]    d1_r;
  logic signed [bnf_pkg::ACC_W-1:0]    d2_r;

  logic signed [bnf_pkg::COEF_W-1:0]   mul_a;
  logic signed [bnf_pkg::SAMPLE_W-1:0] mul_b;
  logic signed [bnf_pkg::ACC_W-1:0]    prod_nxt;
  logic signed [bnf_pkg::ACC_W-1:0]    y_acc;
  logic signed [bnf_pkg::ACC_W-1:0]    fb_diff;
  logic signed [bnf_pkg::SAMPLE_W-1:0] y_nxt;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= bnf_pkg::RST_B0;
      b1_r <= bnf_pkg::RST_B1;
      b2_r <= bnf_pkg::RST_B2;
      a1_r <= bnf_pkg::RST_A1;
      a2_r <= bnf_pkg::RST_A2;
    end else if (cfg_we) begin
      priority case (cfg_index)
        bnf_pkg::CFG_B0: b0_r <= cfg_data;
        bnf_pkg::CFG_B1: b1_r <= cfg_data;
        bnf_pkg::CFG_B2: b2_r <= cfg_data;
        bnf_pkg::CFG_A1: a1_r <= cfg_data;
        bnf_pkg::CFG_A2: a2_r <= cfg_data;
        default: b0_r <= b0_r;
      endcase
    end
  end

  // multiplier operand selection
  always_comb begin
    unique case (cmd.mul_sel)
      bnf_pkg::MUL_B0_IN: begin mul_a = b0_r; mul_b = in_sample_in; end
      bnf_pkg::MUL_B1_X:  begin mul_a = b1_r; mul_b = x_r;          end
      bnf_pkg::MUL_A1_Y:  begin mul_a = a1_r; mul_b = y_r;          end
      bnf_pkg::MUL_B2_X:  begin mul_a = b2_r; mul_b = x_r;          end
      bnf_pkg::MUL_A2_Y:  begin mul_a = a2_r; mul_b = y_r;          end
      default:            begin mul_a = b0_r; mul_b = x_r;          end
    endcase
  end

  // signed product, full 64 bits
  assign prod_nxt = mul_a * mul_b;

  // output accumulator and scaling back to sample format
  assign y_acc   = prod_r + d1_r;
  assign y_nxt   = bnf_pkg::SAMPLE_W'(y_acc >>> bnf_pkg::COEF_FRAC_BITS);
  assign fb_diff = acc_r - prod_r;

  // sample and product registers
  always_ff @(posedge clk) begin
    if (cmd.take)   x_r    <= in_sample_in;
    if (cmd.mul_en) prod_r <= prod_nxt;
    if (cmd.ld_y)   y_r    <= y_nxt;
    if (cmd.ld_out) out_r  <= y_r;
    if (cmd.ld_acc_d2) begin
      acc_r <= prod_r + d2_r;
    end else if (cmd.ld_acc_p) begin
      acc_r <= prod_r;
    end
  end

  // filter delays, cleared on reset or on a restart item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else begin
      if (cmd.take && in_restart) begin
        d1_r <= '0;
        d2_r <= '0;
      end
      if (cmd.ld_d1) d1_r <= fb_diff;
      if (cmd.ld_d2) d2_r <= fb_diff;
    end
  end

  assign out_sample_out = out_r;

endmodule

// ----- hdl/bnf_checker.sv -----
// ---------------------------------------------------------------------------
// bnf_port_checks
// port-level checks of the biquad notch filter, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bnf_port_checks (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_we,
  input logic [bnf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [bnf_pkg::COEF_W-1:0]          cfg_data,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [bnf_pkg::SAMPLE_W-1:0] in_sample_in,
  input logic                                in_restart,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [bnf_pkg::SAMPLE_W-1:0] out_sample_out
);

  // a stalled result stays put
  `BNF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample_out))

  // one item at a time: busy right after an item is taken
  `BNF_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)

  // a result is on offer once an item taken has been stepped through to upd
  `BNF_ASSERT_SAME(a_result_due, clk, rst_n, in_valid && in_ready, ##6 out_valid)

endmodule

bind biquad_notch_filter_q30 bnf_port_checks u_bnf_port_checks (.*);

// ----- tb/bnf_checker.sv -----
// ---------------------------------------------------------------------------
// bnf_checker
// watches the channels of the biquad notch filter, predicts each filtered
// sample from its own copy of coefficients and delays, and compares in order
// ---------------------------------------------------------------------------
module bnf_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bnf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bnf_pkg::COEF_W-1:0]          cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [bnf_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                in_restart,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [bnf_pkg::SAMPLE_W-1:0] out_sample_out,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  checked
);
  import bnf_pkg::*;

  // shadow coefficients and delay line
  logic signed [COEF_W-1:0]   ff0, ff1, ff2, fb1, fb2;
  logic signed [ACC_W-1:0]    state_near, state_far;
  logic signed [SAMPLE_W-1:0] expected_samples[$];

  // one step of the transposed direct form ii section, wrapping at 64 bits
  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
    input logic signed [SAMPLE_W-1:0] x,
    input logic                       clr
  );
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    scaled;
    logic signed [SAMPLE_W-1:0] y;
    if (clr) begin
      state_near = '0;
      state_far  = '0;
    end
    acc        = ff0 * x + state_near;
    scaled     = acc >>> COEF_FRAC_BITS;
    y          = scaled[SAMPLE_W-1:0];
    state_near = ff1 * x + state_far - fb1 * y;
    state_far  = ff2 * x - fb2 * y;
    return y;
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      ff0        = RST_B0;
      ff1        = RST_B1;
      ff2        = RST_B2;
      fb1        = RST_A1;
      fb2        = RST_A2;
      state_near = '0;
      state_far  = '0;
      expected_samples.delete();
    end else begin
      // result side first: a sample can never leave in the cycle it enters
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: no item expected, got %0d", out_sample_out);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_out !== want) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want, out_sample_out);
            fail_count++;
          end
          checked++;
        end
      end
      if (in_valid && in_ready)
        expected_samples.push_back(filter_sample(in_sample_in, in_restart));
      // coefficient writes; indexes past the last register are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_B0:  ff0 = cfg_data;
          CFG_B1:  ff1 = cfg_data;
          CFG_B2:  ff2 = cfg_data;
          CFG_A1:  fb1 = cfg_data;
          CFG_A2:  fb2 = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_samples.size();
  end

endmodule

// ----- tb/tb_biquad_notch_filter_q30.sv -----
// ---------------------------------------------------------------------------
// tb_biquad_notch_filter_q30
// drives samples and coefficient sets into the biquad notch filter
// ---------------------------------------------------------------------------
// directed extremes under the default notch, saturated and unity coefficients,
// then random samples with restarts over several coefficient sets; both sides
// stall at random, with one long back-pressure stretch and one calm stretch
// ---------------------------------------------------------------------------
module tb_biquad_notch_filter_q30;
  import bnf_pkg::*;

  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 250;
  localparam int LONG_HOLD  = 300;
  localparam int HOLD_AT    = 500;
  localparam int CALM_FROM  = 1000;
  localparam int CALM_TO    = 1150;
  localparam int QUIET_MAX  = 4000;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh80000000;
  localparam logic signed [COEF_W-1:0]   C_ONE = 32'sh40000000;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [COEF_W-1:0]          cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       in_restart;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int restarts;
  int coef_sets;
  int quiet;
  logic calm;
  logic held_long;

  always #1 clk = ~clk;

  biquad_notch_filter_q30 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out)
  );

  bnf_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked)
  );

  // offer one item from a falling edge and return at the falling edge after it is taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic clr);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_sample_in = x;
    in_restart   = clr;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (clr) restarts++;
    @(negedge clk);
  endtask

  // close the phase: stop offering and wait until every sample has come back
  task automatic drain;
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                            input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2);
    write_coef(CFG_B0, b0);
    write_coef(CFG_B1, b1);
    write_coef(CFG_B2, b2);
    write_coef(CFG_A1, a1);
    write_coef(CFG_A2, a2);
    coef_sets++;
  endtask

  // coefficient flavours: full range, scaled down, or saturated
  function automatic logic signed [COEF_W-1:0] pick_coef(input int flavour);
    logic signed [COEF_W-1:0] c;
    c = $urandom;
    case (flavour)
      1:       c = c >>> $urandom_range(1, 4);
      2:       c = $urandom_range(0, 1) ? S_MAX : S_MIN;
      default: ;
    endcase
    return c;
  endfunction

  // mostly full-range samples, with extremes and small values mixed in
  function automatic logic signed [SAMPLE_W-1:0] pick_sample;
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = S_MAX;
      1:       s = S_MIN;
      2:       s = $signed($urandom_range(0, 255)) - 128;
      default: s = $urandom;
    endcase
    return s;
  endfunction

  // receiver: random stalls, one long hold-off, none in the calm stretch
  initial begin
    out_ready = 1'b0;
    held_long = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_long && sent >= HOLD_AT) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held_long = 1'b1;
      end
      out_ready = calm || ($urandom_range(0, 99) >= 36);
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("timeout: no traffic for %0d cycles", quiet);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    in_restart   = 1'b0;
    calm         = 1'b0;
    sent         = 0;
    restarts     = 0;
    coef_sets    = 0;
    quiet        = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // default notch straight out of reset
    send_sample('0, 1'b1);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b0);
    send_sample('0, 1'b0);
    send_sample(S_MIN, 1'b1);
    send_sample(S_MAX, 1'b0);
    drain();

    // saturated coefficients force wrap of accumulator and output
    load_coefs(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample(-1, 1'b0);
    drain();
    load_coefs(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    drain();

    // unity pass-through; writes past the last register must not land
    load_coefs(C_ONE, '0, '0, '0, '0);
    for (int i = 1; i <= 3; i++)
      write_coef(CFG_IDX_W'(CFG_A2 + i), $urandom);
    send_sample(32'sh55555555, 1'b1);
    send_sample(32'shaaaaaaaa, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    drain();

    // random phases, each after loading a coefficient set
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0, 5:    load_coefs(RST_B0, RST_B1, RST_B2, RST_A1, RST_A2);
        3:       load_coefs(pick_coef(2), pick_coef(2), pick_coef(2), pick_coef(2),
                            pick_coef(2));
        default: load_coefs(pick_coef(ph % 2), pick_coef(ph % 2), pick_coef(ph % 2),
                            pick_coef(ph % 2), pick_coef(ph % 2));
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        calm = (sent >= CALM_FROM) && (sent < CALM_TO);
        send_sample(pick_sample(), $urandom_range(0, 99) < 4);
      end
      calm = 1'b0;
      drain();
    end

    repeat (20) @(negedge clk);
    $display("filtered %0d samples (%0d with restart) under %0d coefficient settings,",
             checked, restarts, coef_sets + 1);
    $display("including saturated and unity sets, a long output stall and a stall-free run");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/bnf_pkg.sv
hdl/bnf_ctrl.sv
hdl/bnf_dp.sv
hdl/biquad_notch_filter_q30.sv
hdl/bnf_checker.sv
tb/bnf_checker.sv
tb/tb_biquad_notch_filter_q30.sv
